### rtl/core/msp_pkg.sv
package msp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned DataW  = 7;
    localparam int unsigned KindW  = 4;
    localparam int unsigned ValueW = 14;

    localparam logic [ByteW-1:0] StSysexStart = 8'hF0;
    localparam logic [ByteW-1:0] StSysexEnd   = 8'hF7;
    localparam logic [ByteW-1:0] StSongPos    = 8'hF2;
    localparam logic [ByteW-1:0] StSongSel    = 8'hF3;
    localparam logic [ByteW-1:0] StTune       = 8'hF6;
    localparam logic [ByteW-1:0] StClock      = 8'hF8;
    localparam logic [ByteW-1:0] StStart      = 8'hFA;
    localparam logic [ByteW-1:0] StContinue   = 8'hFB;
    localparam logic [ByteW-1:0] StStop       = 8'hFC;
    localparam logic [ByteW-1:0] StSensing    = 8'hFE;
    localparam logic [ByteW-1:0] Low7Mask     = 8'b0111_1111;

    localparam logic [KindW-1:0] KindSysexId   = 4'd0;
    localparam logic [KindW-1:0] KindSysexData = 4'd1;
    localparam logic [KindW-1:0] KindSysexEnd  = 4'd2;
    localparam logic [KindW-1:0] KindSongPos   = 4'd3;
    localparam logic [KindW-1:0] KindSongSel   = 4'd4;
    localparam logic [KindW-1:0] KindTune      = 4'd5;
    localparam logic [KindW-1:0] KindClock     = 4'd6;
    localparam logic [KindW-1:0] KindStart     = 4'd7;
    localparam logic [KindW-1:0] KindContinue  = 4'd8;
    localparam logic [KindW-1:0] KindStop      = 4'd9;
    localparam logic [KindW-1:0] KindSensing   = 4'd10;
    localparam logic [KindW-1:0] KindUnknown   = 4'd11;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_SX_ID    = 6'b000010,
        PH_SX_DATA  = 6'b000100,
        PH_SPP_LO   = 6'b001000,
        PH_SPP_HI   = 6'b010000,
        PH_SONG_SEL = 6'b100000
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic [KindW-1:0]  kind;
        logic [ValueW-1:0] value;
    } t_result;

endpackage

### rtl/core/msp_in_reg.sv
module msp_in_reg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [msp_pkg::ByteW-1:0] i_byte,
    input  logic                     i_fire,
    output logic                     o_ready,
    output logic                     o_valid,
    output logic [msp_pkg::ByteW-1:0] o_byte
);

    logic                      r_valid;
    logic [msp_pkg::ByteW-1:0] r_byte;

    // slot frees up when the held item is consumed this cycle
    assign o_ready = !r_valid || i_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

### rtl/core/msp_decode.sv
module msp_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [msp_pkg::ByteW-1:0] i_byte,
    input  logic                      i_fire,
    output msp_pkg::t_result          o_res
);

    msp_pkg::t_phase           r_phase;
    msp_pkg::t_phase           n_phase;
    logic [msp_pkg::DataW-1:0] r_held;
    logic [msp_pkg::DataW-1:0] n_held;
    logic [msp_pkg::ByteW-1:0] masked;
    logic [msp_pkg::DataW-1:0] d;
    msp_pkg::t_result          res;

    assign masked = i_byte & msp_pkg::Low7Mask;
    assign d      = masked[msp_pkg::DataW-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        res.valid = 1'b1;
        res.kind  = msp_pkg::KindUnknown;
        res.value = '0;
        unique case (r_phase)
            msp_pkg::PH_SX_ID: begin
                n_phase   = msp_pkg::PH_SX_DATA;
                res.kind  = msp_pkg::KindSysexId;
                res.value = {{(msp_pkg::ValueW-msp_pkg::DataW){1'b0}}, d};
            end
            msp_pkg::PH_SX_DATA: begin
                if (i_byte == msp_pkg::StSysexEnd) begin
                    n_phase  = msp_pkg::PH_IDLE;
                    res.kind = msp_pkg::KindSysexEnd;
                end else begin
                    res.kind  = msp_pkg::KindSysexData;
                    res.value = {{(msp_pkg::ValueW-msp_pkg::DataW){1'b0}}, d};
                end
            end
            msp_pkg::PH_SPP_LO: begin
                n_held    = d;
                n_phase   = msp_pkg::PH_SPP_HI;
                res.valid = 1'b0;
            end
            msp_pkg::PH_SPP_HI: begin
                n_phase   = msp_pkg::PH_IDLE;
                res.kind  = msp_pkg::KindSongPos;
                res.value = {d, r_held};
            end
            msp_pkg::PH_SONG_SEL: begin
                n_phase   = msp_pkg::PH_IDLE;
                res.kind  = msp_pkg::KindSongSel;
                res.value = {{(msp_pkg::ValueW-msp_pkg::DataW){1'b0}}, d};
            end
            default: begin
                n_phase = msp_pkg::PH_IDLE;
                unique case (i_byte)
                    msp_pkg::StSysexStart: begin
                        n_phase   = msp_pkg::PH_SX_ID;
                        res.valid = 1'b0;
                    end
                    msp_pkg::StSongPos: begin
                        n_phase   = msp_pkg::PH_SPP_LO;
                        res.valid = 1'b0;
                    end
                    msp_pkg::StSongSel: begin
                        n_phase   = msp_pkg::PH_SONG_SEL;
                        res.valid = 1'b0;
                    end
                    msp_pkg::StTune:     res.kind = msp_pkg::KindTune;
                    msp_pkg::StClock:    res.kind = msp_pkg::KindClock;
                    msp_pkg::StStart:    res.kind = msp_pkg::KindStart;
                    msp_pkg::StContinue: res.kind = msp_pkg::KindContinue;
                    msp_pkg::StStop:     res.kind = msp_pkg::KindStop;
                    msp_pkg::StSensing:  res.kind = msp_pkg::KindSensing;
                    default:             res.kind = msp_pkg::KindUnknown;
                endcase
            end
        endcase
        res.valid = res.valid && i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= msp_pkg::PH_IDLE;
            r_held  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign o_res = res;

endmodule

### rtl/core/msp_out_reg.sv
module msp_out_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  msp_pkg::t_result           i_res,
    input  logic                       i_m_tready,
    output logic                       o_ready,
    output logic                       o_m_tvalid,
    output logic [msp_pkg::KindW-1:0]  o_kind,
    output logic [msp_pkg::ValueW-1:0] o_value
);

    logic                       r_valid;
    logic [msp_pkg::KindW-1:0]  r_kind;
    logic [msp_pkg::ValueW-1:0] r_value;

    assign o_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res.valid) begin
            r_kind  <= i_res.kind;
            r_value <= i_res.value;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_kind     = r_kind;
    assign o_value    = r_value;

endmodule

### rtl/core/midi_system_message_parser.sv
// MIDI system message parser.
// Slave channel: one raw MIDI byte per item on i_s_tdata.
// Master channel: one event per item; o_m_tuser carries the event kind,
// o_m_tdata the 7-bit id/data/song number or 14-bit song position.
// Status bytes F0, F2, F3 and the song position low byte produce no event.
// A byte accepted on the slave side passes through the input register,
// then the result register, before its event shows on the master side.
// Throughput: one byte per cycle sustained while the receiver keeps up;
// the parse state update is a single decode step between the two registers.
// When the receiver stalls, the event holds in the result register and
// the input register absorbs one more byte; o_s_tready drops only when
// both are full and the pending byte would produce an event.
// Reset (synchronous, active low) empties both registers, returns the
// parser to idle and clears the held song position low byte.
module midi_system_message_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [13:0] event_value, [15:14] zero
    output logic [3:0]  o_m_tuser    // [3:0] event_kind
);

    logic                       in_valid;
    logic [msp_pkg::ByteW-1:0]  in_byte;
    logic                       out_ready;
    logic                       fire;
    msp_pkg::t_result           res;
    logic [msp_pkg::ValueW-1:0] value;

    assign fire = in_valid && (!res.valid || out_ready);

    msp_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_fire  (fire),
        .o_ready (o_s_tready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    msp_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_byte  (in_byte),
        .i_fire  (fire),
        .o_res   (res)
    );

    msp_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .i_m_tready (i_m_tready),
        .o_ready    (out_ready),
        .o_m_tvalid (o_m_tvalid),
        .o_kind     (o_m_tuser),
        .o_value    (value)
    );

    assign o_m_tdata = {2'b00, value};

endmodule

### rtl/core/msp_checker.sv
module msp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic [3:0]  i_m_tuser
);

    // output register is empty the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("event valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser))
        else $error("stalled event changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tuser <= msp_pkg::KindUnknown)
        else $error("event kind out of range");

    // only song position may exceed 7 bits; status-only events carry zero
    a_value_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[15:14] == 2'b00)
            && ((i_m_tuser == msp_pkg::KindSongPos) || (i_m_tdata[13:7] == '0))
            && ((i_m_tuser == msp_pkg::KindSysexId)
                || (i_m_tuser == msp_pkg::KindSysexData)
                || (i_m_tuser == msp_pkg::KindSongPos)
                || (i_m_tuser == msp_pkg::KindSongSel)
                || (i_m_tdata == '0)))
        else $error("event value malformed");

    // an empty or draining result register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_m_tvalid || i_m_tready) |-> i_s_tready)
        else $error("input blocked while output free");

endmodule

bind midi_system_message_parser msp_checker u_msp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
